>>> hw/rtl/ovf_pkg.sv
// Shared types, character codes and defaults for the vertex/face record parser.
package ovf_pkg;

   // Default configuration of the value path.
   localparam int DEF_VALUE_WIDTH     = 32;
   localparam int DEF_FRAC_BITS       = 16;
   localparam int DEF_MAX_FRAC_DIGITS = 5;

   // Fixed widths of the channel fields.
   localparam int BYTE_W  = 8;
   localparam int FIELD_W = 32;
   localparam int PLACE_W = 3;
   localparam int DIGIT_W = 4;

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_V     = 8'h76;
   localparam logic [BYTE_W-1:0] CH_F     = 8'h66;

   // Record kind codes on the result channel.
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_FACE   = 1'b1;

   // Record state: outside a record, in a vertex record, in a face record.
   typedef enum logic [2:0] {
      MODE_NONE   = 3'b001,
      MODE_VERTEX = 3'b010,
      MODE_FACE   = 3'b100
   } mode_type;

   // Number scanning state.
   typedef enum logic [2:0] {
      PHASE_NONE  = 3'b001,
      PHASE_WHOLE = 3'b010,
      PHASE_FRAC  = 3'b100
   } phase_type;

   // Token classes handed from the number scanner to the record builder.
   typedef enum logic [1:0] {
      TOK_VMARK = 2'd0,
      TOK_FMARK = 2'd1,
      TOK_INT   = 2'd2,
      TOK_REAL  = 2'd3
   } token_kind_type;

   // Control that travels with one token.
   typedef struct packed {
      logic           valid;
      token_kind_type kind;
      logic           negative;
      logic           last;
   } token_type;

   // One registered input word.
   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              stream_end;
   } req_word_type;

endpackage

>>> hw/rtl/ovf_channels.sv
// Valid/ready channel interfaces for the request and response sides of the parser.
interface ovf_req_if;
   logic                         valid;
   logic                         ready;
   logic [ovf_pkg::BYTE_W-1:0]   text_byte;
   logic                         stream_end;

   modport source (output valid, output text_byte, output stream_end, input ready);
   modport sink (input valid, input text_byte, input stream_end, output ready);
endinterface

interface ovf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                record_kind;
   logic signed [ovf_pkg::FIELD_W-1:0]  first_value;
   logic signed [ovf_pkg::FIELD_W-1:0]  second_value;
   logic signed [ovf_pkg::FIELD_W-1:0]  third_value;
   logic                                clipped;

   modport source (output valid, output record_kind, output first_value,
                   output second_value, output third_value, output clipped, input ready);
   modport sink (input valid, input record_kind, input first_value,
                 input second_value, input third_value, input clipped, output ready);
endinterface

>>> hw/rtl/ovf_input_stage.sv
// Input register that holds one text word until the scanner consumes it.
module ovf_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   ovf_req_if.sink               req_channel,
   input  logic                  take,
   output logic                  word_valid,
   output ovf_pkg::req_word_type word
);
   import ovf_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   logic         accept;
   req_word_type word_ff;

   // A new word is taken whenever the register is empty or is drained this cycle.
   assign req_channel.ready = !valid_ff || take;
   assign accept            = req_channel.valid && req_channel.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff.text_byte  <= req_channel.text_byte;
         word_ff.stream_end <= req_channel.stream_end;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

>>> hw/rtl/ovf_number_scan.sv
// Number scanner: accumulates whole and fraction digits and emits tokens.
module ovf_number_scan #(
   parameter int VALUE_WIDTH     = ovf_pkg::DEF_VALUE_WIDTH,
   parameter int FRAC_BITS       = ovf_pkg::DEF_FRAC_BITS,
   parameter int MAX_FRAC_DIGITS = ovf_pkg::DEF_MAX_FRAC_DIGITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  ovf_pkg::req_word_type   word,
   output ovf_pkg::token_type      token,
   output logic [VALUE_WIDTH-1:0]  token_whole,
   output logic [FRAC_BITS+1:0]    token_frac
);
   import ovf_pkg::*;

   localparam int FRAC_W = FRAC_BITS + 2;
   localparam int WIDE_W = VALUE_WIDTH + 4;
   localparam logic [63:0] ONE2 = 64'd1 << (FRAC_BITS + 1);

   // Rounded weight of one unit at each fraction place.
   localparam logic [63:0] FRAC_WEIGHT [8] = '{
      64'd0,
      ((ONE2 / 64'd10) + 64'd1) / 64'd2,
      ((ONE2 / 64'd100) + 64'd1) / 64'd2,
      ((ONE2 / 64'd1000) + 64'd1) / 64'd2,
      ((ONE2 / 64'd10000) + 64'd1) / 64'd2,
      ((ONE2 / 64'd100000) + 64'd1) / 64'd2,
      ((ONE2 / 64'd1000000) + 64'd1) / 64'd2,
      ((ONE2 / 64'd10000000) + 64'd1) / 64'd2
   };

   localparam logic [WIDE_W-1:0] WHOLE_CAP = (WIDE_W'(1) << (VALUE_WIDTH - 1)) + WIDE_W'(1);

   phase_type               phase_ff, phase_in, phase_upd;
   logic                    neg_ff, neg_in, neg_upd;
   logic [VALUE_WIDTH-1:0]  whole_ff, whole_in, whole_upd;
   logic [FRAC_W-1:0]       frac_ff, frac_in, frac_upd;
   logic [PLACE_W-1:0]      place_ff, place_in, place_upd;

   logic                    digit;
   logic [DIGIT_W-1:0]      digit_value;
   logic [WIDE_W-1:0]       whole_x10;
   logic [VALUE_WIDTH-1:0]  whole_acc;
   logic [PLACE_W-1:0]      place_next;
   logic [FRAC_W-1:0]       weight;
   logic [FRAC_W-1:0]       frac_acc;
   logic                    terminate;
   logic                    mark;
   token_kind_type          mark_kind;
   logic                    clear;

   // Character classification.
   assign digit       = (word.text_byte >= CH_ZERO) && (word.text_byte <= CH_NINE);
   assign digit_value = digit ? DIGIT_W'(word.text_byte - CH_ZERO) : '0;

   // Whole part times ten plus the digit, held at the cap once it is passed.
   assign whole_x10 = (WIDE_W'(whole_ff) << 3) + (WIDE_W'(whole_ff) << 1)
                      + WIDE_W'(digit_value);
   assign whole_acc = (whole_x10 > WHOLE_CAP) ? VALUE_WIDTH'(WHOLE_CAP)
                                              : VALUE_WIDTH'(whole_x10);

   // Fraction digit adds its weight at the next place.
   assign place_next = place_ff + PLACE_W'(1);
   assign weight     = FRAC_W'(FRAC_WEIGHT[place_next]);
   assign frac_acc   = frac_ff + FRAC_W'(weight * FRAC_W'(digit_value));

   // Number state after this byte, before any termination.
   always_comb begin
      phase_upd = phase_ff;
      neg_upd   = neg_ff;
      whole_upd = whole_ff;
      frac_upd  = frac_ff;
      place_upd = place_ff;
      terminate = 1'b0;
      mark      = 1'b0;
      mark_kind = TOK_VMARK;
      unique case (phase_ff)
         PHASE_WHOLE: begin
            if (digit) begin
               whole_upd = whole_acc;
            end else if (word.text_byte == CH_POINT) begin
               phase_upd = PHASE_FRAC;
            end else begin
               terminate = 1'b1;
            end
         end
         PHASE_FRAC: begin
            if (digit) begin
               if (place_ff < PLACE_W'(MAX_FRAC_DIGITS)) begin
                  place_upd = place_next;
                  frac_upd  = frac_acc;
               end
            end else begin
               terminate = 1'b1;
            end
         end
         PHASE_NONE: begin
            if (digit || (word.text_byte == CH_MINUS)) begin
               phase_upd = PHASE_WHOLE;
               neg_upd   = (word.text_byte == CH_MINUS);
               whole_upd = VALUE_WIDTH'(digit_value);
               frac_upd  = '0;
               place_upd = '0;
            end else if (word.text_byte == CH_V) begin
               mark      = 1'b1;
               mark_kind = TOK_VMARK;
            end else if (word.text_byte == CH_F) begin
               mark      = 1'b1;
               mark_kind = TOK_FMARK;
            end
         end
         default: begin
            terminate = 1'b0;
         end
      endcase
   end

   // Token out: a record mark, a terminated number, or a number closed by stream end.
   always_comb begin
      token.valid    = mark || terminate || (word.stream_end && (phase_upd != PHASE_NONE));
      token.negative = neg_upd;
      token.last     = word.stream_end;
      if (mark) begin
         token.kind = mark_kind;
      end else if (phase_upd == PHASE_FRAC) begin
         token.kind = TOK_REAL;
      end else begin
         token.kind = TOK_INT;
      end
   end

   assign token_whole = whole_upd;
   assign token_frac  = frac_upd;

   // Next number state: cleared after a token is taken or at stream end.
   assign clear = terminate || word.stream_end;

   always_comb begin
      if (clear) begin
         phase_in = PHASE_NONE;
         neg_in   = 1'b0;
         whole_in = '0;
         frac_in  = '0;
         place_in = '0;
      end else begin
         phase_in = phase_upd;
         neg_in   = neg_upd;
         whole_in = whole_upd;
         frac_in  = frac_upd;
         place_in = place_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_NONE;
         neg_ff   <= 1'b0;
         whole_ff <= '0;
         frac_ff  <= '0;
         place_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         whole_ff <= whole_in;
         frac_ff  <= frac_in;
         place_ff <= place_in;
      end
   end

endmodule

>>> hw/rtl/ovf_record_build.sv
// Record builder: converts tokens to slot values and registers finished records.
module ovf_record_build #(
   parameter int VALUE_WIDTH = ovf_pkg::DEF_VALUE_WIDTH,
   parameter int FRAC_BITS   = ovf_pkg::DEF_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  ovf_pkg::token_type      token,
   input  logic [VALUE_WIDTH-1:0]  token_whole,
   input  logic [FRAC_BITS+1:0]    token_frac,
   output logic                    out_free,
   ovf_rsp_if.source               rsp_channel
);
   import ovf_pkg::*;

   localparam int FRAC_W = FRAC_BITS + 2;
   localparam int MAG_W  = ((VALUE_WIDTH > FRAC_W) ? VALUE_WIDTH : FRAC_W) + 2;
   localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(1) << (VALUE_WIDTH - 1);
   localparam logic [MAG_W-1:0] LIM_POS = LIM_NEG - MAG_W'(1);

   mode_type                mode_ff, mode_in;
   logic [1:0]              count_ff, count_in;
   logic                    clip_ff, clip_in;
   logic [VALUE_WIDTH-1:0]  slot_ff [2];
   logic                    slot_write;

   logic                    out_valid_ff, out_valid_in;
   logic                    kind_ff;
   logic [FIELD_W-1:0]      value_ff [3];
   logic                    clipped_ff;

   logic [MAG_W-1:0]        limit;
   logic [MAG_W-1:0]        whole_mag;
   logic [MAG_W-1:0]        vertex_mag;
   logic [MAG_W-1:0]        mag;
   logic                    saturate;
   logic [MAG_W-1:0]        sat_mag;
   logic [VALUE_WIDTH-1:0]  value;
   logic                    is_number;
   logic                    emit;

   // Magnitude limit depends on the sign.
   assign limit     = token.negative ? LIM_NEG : LIM_POS;
   assign whole_mag = MAG_W'(token_whole);

   // Fixed-point magnitude; an oversize whole part forces saturation.
   assign vertex_mag = (whole_mag > (limit >> FRAC_BITS)) ? (limit + MAG_W'(1))
                       : ((whole_mag << FRAC_BITS) + MAG_W'(token_frac));

   // Slot magnitude: mismatched tokens give zero.
   assign is_number = (token.kind == TOK_INT) || (token.kind == TOK_REAL);

   always_comb begin
      if ((mode_ff == MODE_VERTEX) && is_number) begin
         mag = vertex_mag;
      end else if ((mode_ff == MODE_FACE) && (token.kind == TOK_INT)) begin
         mag = whole_mag;
      end else begin
         mag = '0;
      end
   end

   // Saturate and apply the sign.
   assign saturate = mag > limit;
   assign sat_mag  = saturate ? limit : mag;
   assign value    = token.negative ? VALUE_WIDTH'(-sat_mag) : VALUE_WIDTH'(sat_mag);

   // Record sequencing.
   always_comb begin
      mode_in    = mode_ff;
      count_in   = count_ff;
      clip_in    = clip_ff;
      slot_write = 1'b0;
      emit       = 1'b0;
      if (token.valid) begin
         if (mode_ff == MODE_NONE) begin
            if (token.kind == TOK_VMARK) begin
               mode_in  = MODE_VERTEX;
               count_in = '0;
               clip_in  = 1'b0;
            end else if (token.kind == TOK_FMARK) begin
               mode_in  = MODE_FACE;
               count_in = '0;
               clip_in  = 1'b0;
            end
         end else begin
            clip_in = clip_ff || saturate;
            if (count_ff == 2'd2) begin
               emit     = 1'b1;
               mode_in  = MODE_NONE;
               count_in = '0;
            end else begin
               slot_write = 1'b1;
               count_in   = count_ff + 2'd1;
            end
         end
      end
      // Stream end drops any partial record.
      if (token.last) begin
         mode_in  = MODE_NONE;
         count_in = '0;
         clip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NONE;
         count_ff <= '0;
         clip_ff  <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         clip_ff  <= clip_in;
      end
   end

   // Slot storage for the first two values of a record.
   always_ff @(posedge clock) begin
      if (step && slot_write) begin
         slot_ff[count_ff[0]] <= value;
      end
   end

   // Result register; it frees when the consumer takes the word.
   assign out_free = !out_valid_ff || rsp_channel.ready;

   always_comb begin
      if (step && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         kind_ff     <= (mode_ff == MODE_FACE) ? KIND_FACE : KIND_VERTEX;
         value_ff[0] <= FIELD_W'($signed(slot_ff[0]));
         value_ff[1] <= FIELD_W'($signed(slot_ff[1]));
         value_ff[2] <= FIELD_W'($signed(value));
         clipped_ff  <= clip_ff || saturate;
      end
   end

   assign rsp_channel.valid        = out_valid_ff;
   assign rsp_channel.record_kind  = kind_ff;
   assign rsp_channel.first_value  = value_ff[0];
   assign rsp_channel.second_value = value_ff[1];
   assign rsp_channel.third_value  = value_ff[2];
   assign rsp_channel.clipped      = clipped_ff;

endmodule

>>> hw/rtl/obj_vertex_face_record_parser.sv
// Top level of the vertex/face record parser: text bytes in, parsed records out.
// The parser takes one text byte per clock cycle and keeps that rate as long as
// the result side accepts records; while a finished record waits in the result
// register and is not taken, the held byte and the input stall. A byte passes
// through an input register, then one pass of digit accumulation, fixed-point
// conversion and saturation, and lands in the result register. The digit
// accumulation of the number scanner followed by the fixed-point shift and add,
// saturation and negation of the record builder set the clock budget of that
// pass. Vertex values are signed fixed point with FRAC_BITS fraction bits, face
// values are integers, and stream_end on a byte finishes any number in progress
// and then drops an incomplete record.
module obj_vertex_face_record_parser #(
   parameter int VALUE_WIDTH     = ovf_pkg::DEF_VALUE_WIDTH,
   parameter int FRAC_BITS       = ovf_pkg::DEF_FRAC_BITS,
   parameter int MAX_FRAC_DIGITS = ovf_pkg::DEF_MAX_FRAC_DIGITS
) (
   input  logic       clock,
   input  logic       reset,
   ovf_req_if.sink    req_channel,
   ovf_rsp_if.source  rsp_channel
);
   import ovf_pkg::*;

   logic                    word_valid;
   req_word_type            word;
   logic                    out_free;
   logic                    step;
   token_type               token;
   logic [VALUE_WIDTH-1:0]  token_whole;
   logic [FRAC_BITS+1:0]    token_frac;

   // A held word is processed whenever the result register can take a record.
   assign step = word_valid && out_free;

   ovf_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .take        (step),
      .word_valid  (word_valid),
      .word        (word)
   );

   ovf_number_scan #(
      .VALUE_WIDTH     (VALUE_WIDTH),
      .FRAC_BITS       (FRAC_BITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .word        (word),
      .token       (token),
      .token_whole (token_whole),
      .token_frac  (token_frac)
   );

   ovf_record_build #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_build (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .token       (token),
      .token_whole (token_whole),
      .token_frac  (token_frac),
      .out_free    (out_free),
      .rsp_channel (rsp_channel)
   );

endmodule

>>> bench/obj_vertex_face_record_parser_tb.sv
// Testbench for the OBJ vertex/face record parser: directed and random text streams checked by a parser model.
`timescale 1ns / 100ps

module obj_vertex_face_record_parser_tb;
   import ovf_pkg::*;

   localparam int VALUE_W     = DEF_VALUE_WIDTH;
   localparam int FRAC_W      = DEF_FRAC_BITS;
   localparam int MAX_PLACES  = DEF_MAX_FRAC_DIGITS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 10;
   localparam int PHASE_ITEMS = 650;

   localparam logic [63:0] RADIX     = 64'd10;
   localparam logic [63:0] WHOLE_CAP = (64'd1 << (VALUE_W - 1)) + 64'd1;

   // Separator bytes used to build text lines.
   localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;

   typedef struct packed {
      logic               kind;
      logic [FIELD_W-1:0] first_value;
      logic [FIELD_W-1:0] second_value;
      logic [FIELD_W-1:0] third_value;
      logic               clipped;
   } record_type;

   logic clock;
   logic reset;

   ovf_req_if req_ch ();
   ovf_rsp_if rsp_ch ();

   obj_vertex_face_record_parser #(
      .VALUE_WIDTH     (VALUE_W),
      .FRAC_BITS       (FRAC_W),
      .MAX_FRAC_DIGITS (MAX_PLACES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch)
   );

   record_type        expected_records[$];
   logic [BYTE_W-1:0] line_bytes[$];
   bit                line_closed_by_end;
   int                send_idle_pct;
   int                take_idle_pct;
   int                fail_count;
   int                cycle_count;

   // Parser model state.
   mode_type    par_mode;
   int          par_slot;
   phase_type   par_phase;
   logic        par_negative;
   logic [63:0] par_whole;
   logic [63:0] par_fraction;
   int          par_place;
   logic [63:0] par_slot_value [3];
   logic        par_clip;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Largest magnitude that fits the signed value range for the given sign.
   function automatic logic [63:0] magnitude_limit(logic negative);
      logic [63:0] top;
      top = 64'd1 << (VALUE_W - 1);
      return negative ? top : top - 64'd1;
   endfunction

   // Rounded fixed-point weight of one unit at a given decimal place.
   function automatic logic [63:0] place_weight(int place);
      logic [63:0] power;
      power = 64'd1;
      for (int i = 0; i < place; i++) power = power * RADIX;
      return (((64'd1 << (FRAC_W + 1)) / power) + 64'd1) / 64'd2;
   endfunction

   // Saturate a magnitude, note the clip, and apply the sign.
   function automatic logic [63:0] apply_sign(logic [63:0] mag, logic negative);
      logic [63:0] lim;
      lim = magnitude_limit(negative);
      if (mag > lim) begin
         mag = lim;
         par_clip = 1'b1;
      end
      return negative ? -mag : mag;
   endfunction

   function automatic logic [63:0] fixed_point_value();
      logic [63:0] lim;
      logic [63:0] mag;
      lim = magnitude_limit(par_negative);
      if (par_whole > (lim >> FRAC_W)) mag = lim + 64'd1;
      else mag = (par_whole << FRAC_W) + par_fraction;
      return apply_sign(mag, par_negative);
   endfunction

   function automatic void clear_number();
      par_phase    = PHASE_NONE;
      par_negative = 1'b0;
      par_whole    = '0;
      par_fraction = '0;
      par_place    = 0;
   endfunction

   function automatic void reset_parser();
      par_mode       = MODE_NONE;
      par_slot       = 0;
      par_slot_value = '{default: '0};
      par_clip       = 1'b0;
      clear_number();
   endfunction

   // Hand one token to the record builder; a third slot closes the record.
   function automatic void take_token(token_kind_type tok);
      logic [63:0] value;
      record_type  rec;
      value = '0;
      if (par_mode == MODE_NONE) begin
         if (tok == TOK_VMARK || tok == TOK_FMARK) begin
            par_mode       = (tok == TOK_VMARK) ? MODE_VERTEX : MODE_FACE;
            par_slot       = 0;
            par_slot_value = '{default: '0};
            par_clip       = 1'b0;
         end
         return;
      end
      if (par_mode == MODE_VERTEX && (tok == TOK_INT || tok == TOK_REAL)) begin
         value = fixed_point_value();
      end else if (par_mode == MODE_FACE && tok == TOK_INT) begin
         value = apply_sign(par_whole, par_negative);
      end
      par_slot_value[par_slot] = value;
      par_slot++;
      if (par_slot == 3) begin
         rec.kind         = (par_mode == MODE_FACE) ? KIND_FACE : KIND_VERTEX;
         rec.first_value  = par_slot_value[0][FIELD_W-1:0];
         rec.second_value = par_slot_value[1][FIELD_W-1:0];
         rec.third_value  = par_slot_value[2][FIELD_W-1:0];
         rec.clipped      = par_clip;
         expected_records.push_back(rec);
         par_mode = MODE_NONE;
         par_slot = 0;
      end
   endfunction

   function automatic void finish_number();
      take_token((par_phase == PHASE_FRAC) ? TOK_REAL : TOK_INT);
      clear_number();
   endfunction

   // Advance the parser model by one accepted text byte.
   function automatic void parse_byte(logic [BYTE_W-1:0] text, logic last);
      logic        is_digit;
      logic [63:0] digit;
      is_digit = (text >= CH_ZERO && text <= CH_NINE);
      digit    = is_digit ? {56'd0, text - CH_ZERO} : 64'd0;
      case (par_phase)
         PHASE_WHOLE: begin
            if (is_digit) begin
               if (par_whole > (WHOLE_CAP - digit) / RADIX) par_whole = WHOLE_CAP;
               else par_whole = par_whole * RADIX + digit;
            end else if (text == CH_POINT) begin
               par_phase = PHASE_FRAC;
            end else begin
               finish_number();
            end
         end
         PHASE_FRAC: begin
            if (is_digit) begin
               if (par_place < MAX_PLACES) begin
                  par_place++;
                  par_fraction = par_fraction + digit * place_weight(par_place);
               end
            end else begin
               finish_number();
            end
         end
         default: begin
            if (is_digit || text == CH_MINUS) begin
               clear_number();
               par_phase    = PHASE_WHOLE;
               par_negative = (text == CH_MINUS);
               par_whole    = digit;
            end else if (text == CH_V) begin
               take_token(TOK_VMARK);
            end else if (text == CH_F) begin
               take_token(TOK_FMARK);
            end
         end
      endcase
      // The final byte finishes a pending number, then everything is cleared.
      if (last) begin
         if (par_phase != PHASE_NONE) finish_number();
         reset_parser();
      end
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   function automatic void compare_field(string name, logic [FIELD_W-1:0] want,
                                         logic [FIELD_W-1:0] got);
      if (got !== want) begin
         note_failure($sformatf("%s expected %0d (%h) got %0d (%h)", name,
                                $signed(want), want, $signed(got), got));
      end
   endfunction

   // Result checker: every accepted record is compared with the oldest expectation.
   always @(posedge clock) begin
      record_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_records.size() == 0) begin
            note_failure($sformatf("record with nothing expected: kind %0d values %0d %0d %0d clip %0d",
                                   rsp_ch.record_kind, rsp_ch.first_value,
                                   rsp_ch.second_value, rsp_ch.third_value, rsp_ch.clipped));
         end else begin
            want = expected_records.pop_front();
            compare_field("record_kind", FIELD_W'(want.kind), FIELD_W'(rsp_ch.record_kind));
            compare_field("first_value", want.first_value, rsp_ch.first_value);
            compare_field("second_value", want.second_value, rsp_ch.second_value);
            compare_field("third_value", want.third_value, rsp_ch.third_value);
            compare_field("clipped", FIELD_W'(want.clipped), FIELD_W'(rsp_ch.clipped));
         end
      end
   end

   // Result side back-pressure.
   always @(negedge clock) rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("obj_vertex_face_record_parser test failed");
         $finish;
      end
   end

   // Send one word; called and returning at a falling edge.
   task automatic send_word(logic [BYTE_W-1:0] text, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.text_byte  <= text;
      req_ch.stream_end <= last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      parse_byte(text, last);
      @(negedge clock);
   endtask

   task automatic send_text(string s, bit end_on_last);
      for (int i = 0; i < s.len(); i++) send_word(s[i], end_on_last && i == s.len() - 1);
   endtask

   // Hold the sender off until every expected record has arrived.
   task automatic wait_records_drained();
      req_ch.valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic void add_digits(int count);
      for (int i = 0; i < count; i++) begin
         line_bytes.push_back(CH_ZERO + BYTE_W'($urandom_range(9)));
      end
   endfunction

   function automatic void add_separator();
      int r;
      r = $urandom_range(99);
      if (r < 70) line_bytes.push_back(CH_SPACE);
      else if (r < 82) line_bytes.push_back(CH_TAB);
      else if (r < 92) line_bytes.push_back(CH_SLASH);
      else if (r < 97) line_bytes.push_back(CH_MINUS);
      else line_bytes.push_back(BYTE_W'($urandom_range(255)));
   endfunction

   // One slot token: mostly numbers, now and then a mark or a bare sign.
   function automatic void add_token(bit face);
      int r;
      r = $urandom_range(99);
      if (r < 4) begin
         line_bytes.push_back($urandom_range(1) ? CH_V : CH_F);
      end else if (r < 8) begin
         line_bytes.push_back(CH_MINUS);
      end else begin
         if ($urandom_range(99) < 30) line_bytes.push_back(CH_MINUS);
         r = $urandom_range(99);
         if (r < 82) add_digits($urandom_range(1, face ? 4 : 5));
         else if (r < 96) add_digits($urandom_range(6, 12));
         if ($urandom_range(99) < (face ? 10 : 65)) begin
            line_bytes.push_back(CH_POINT);
            add_digits($urandom_range(0, 7));
         end
      end
   endfunction

   // Build one record line; a broken line is cut short by the stream end.
   function automatic void build_record_line(bit broken);
      bit face;
      int cut;
      line_bytes.delete();
      face = 1'($urandom_range(1));
      line_bytes.push_back(CH_NEWLINE);
      line_bytes.push_back(face ? CH_F : CH_V);
      if ($urandom_range(99) < 80) add_separator();
      for (int s = 0; s < 3; s++) begin
         add_token(face);
         if (s < 2) add_separator();
      end
      line_closed_by_end = ($urandom_range(99) < 15);
      if (!line_closed_by_end) line_bytes.push_back(CH_NEWLINE);
      if (broken) begin
         cut                = $urandom_range(line_bytes.size() - 1);
         line_bytes         = line_bytes[0:cut];
         line_closed_by_end = 1'b1;
      end
   endfunction

   task automatic send_noise();
      int count;
      count = $urandom_range(1, 6);
      repeat (count) send_word(BYTE_W'($urandom_range(255)), $urandom_range(19) == 0);
   endtask

   // Fixed point: sign without digits, ignored sixth place, rounding past the top.
   task automatic test_vertex_fixed_point();
      send_text("v-.5 9.123456 32767.99999\n", 1'b0);
      send_text("v-32768 32768 0.1\n", 1'b0);
   endtask

   // Face indices at and just past the signed range.
   task automatic test_face_extremes();
      send_text("f-2147483648 2147483647 2147483648\n", 1'b0);
   endtask

   // Bare sign, mark inside a record, second sign, numbers outside a record,
   // point in a fraction, skipped bytes and a real number in a face slot.
   task automatic test_token_repairs();
      send_text("v- f 3-4 1.2.v x", 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_text("f1.5 6\n", 1'b0);
      send_text("f1.5 -0 7.", 1'b0);
      send_text("8 9\n", 1'b0);
   endtask

   // Stream end finishes a number, and drops an incomplete record.
   task automatic test_stream_end();
      send_text("f1.5 -0 7", 1'b1);
      send_text("v1 2", 1'b1);
      send_text("3 4\n", 1'b0);
   endtask

   // Mostly well-formed records with random content, some noise and cut lines.
   task automatic test_random_stream(int send_pct, int take_pct, int target);
      int counted;
      int r;
      bit held;
      send_idle_pct = send_pct;
      take_idle_pct = take_pct;
      counted       = 0;
      held          = 1'b0;
      while (counted < target) begin
         if (!held && counted >= target / 2) begin
            wait_records_drained();
            held = 1'b1;
         end
         r = $urandom_range(99);
         if (r < 10) begin
            send_noise();
         end else begin
            build_record_line(r < 15);
            for (int i = 0; i < line_bytes.size(); i++) begin
               send_word(line_bytes[i], line_closed_by_end && i == line_bytes.size() - 1);
            end
            counted += line_bytes.size();
         end
      end
   endtask

   // Test sequence.
   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.text_byte  = '0;
      req_ch.stream_end = 1'b0;
      send_idle_pct     = 16;
      take_idle_pct     = 73;
      reset_parser();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_vertex_fixed_point();
      test_face_extremes();
      test_token_repairs();
      test_stream_end();
      wait_records_drained();

      test_random_stream(16, 73, PHASE_ITEMS);
      test_random_stream(73, 16, PHASE_ITEMS);
      test_random_stream(0, 0, PHASE_ITEMS);

      wait_records_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_records.size() == 0) begin
         $display("obj_vertex_face_record_parser test passed");
      end else begin
         $display("obj_vertex_face_record_parser test failed");
      end
      $finish;
   end

endmodule
